// ===== hdl/dlle_pkg.sv =====
// Shared definitions for the doubly linked list engine.
// Holds the operation and status codes and the node memory field write-enable struct.
// No dependencies.
package dlle_pkg;

   // Fixed widths of the item fields.
   localparam int OP_W     = 4;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 8;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [OP_W-1:0] OP_INS_AFTER  = 4'd2;
   localparam logic [OP_W-1:0] OP_INS_BEFORE = 4'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 4'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 4'd5;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd6;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd7;
   localparam logic [OP_W-1:0] OP_DROP_FRONT = 4'd8;
   localparam logic [OP_W-1:0] OP_DROP_BACK  = 4'd9;
   localparam logic [OP_W-1:0] OP_REMOVE_KEY = 4'd10;
   localparam logic [OP_W-1:0] OP_FIND       = 4'd11;
   localparam logic [OP_W-1:0] OP_CLEAR      = 4'd12;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // Per-field write enables of one node memory write.
   typedef struct packed {
      logic val;
      logic nxt;
      logic prv;
   } field_we_type;

endpackage

// ===== hdl/doubly_linked_list_engine.sv =====
// Doubly linked list engine: top level with the operation sequencer and the result register.
// Instantiates dlle_node_ram; uses codes and types from dlle_pkg.
//
// The engine keeps a bounded circular doubly linked list of signed values in a node memory of
// NODE_COUNT entries; node 0 is the sentinel, whose front and back links live in registers, and
// nodes 1 to NODE_COUNT-1 come from a free chain. Every item carries one operation and gives
// exactly one result with a status, the data read, a found flag, an empty flag and the length
// after the operation. Items are handled one at a time; the engine accepts the next item as soon
// as the previous result sits in the output register, even while that result is still stalled.
// The pace is set by the node memory, which the sequencer uses for one read or one write per cycle.
// Clear, the spare codes and the empty, full and not-found shortcuts go straight to the result
// state; peek reads the end node, push allocates and links a node, and pop and drop read and
// unlink the end node. Key operations walk the list one node per cycle from the front, then
// insert or remove; a key that is absent walks the whole list. There is no clearing pass after
// reset: a fill mark tracks the part of the pool that was never handed out, and those nodes are
// chained implicitly, so the engine is ready as soon as reset is released.
module doubly_linked_list_engine #(
   parameter int NODE_COUNT = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_operation,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic               rsp_found,
   output logic               rsp_is_empty,
   output logic [7:0]         rsp_length
);

   localparam int IDX_W    = $clog2(NODE_COUNT);
   localparam int FILL_W   = $clog2(NODE_COUNT + 1);
   localparam int OP_W     = dlle_pkg::OP_W;
   localparam int FIELD_W  = dlle_pkg::FIELD_W;
   localparam int STATUS_W = dlle_pkg::STATUS_W;
   localparam int LEN_W    = dlle_pkg::LEN_W;

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ALLOC    = 4'd1;
   localparam logic [3:0] S_LINK     = 4'd2;
   localparam logic [3:0] S_LINK_B   = 4'd3;
   localparam logic [3:0] S_SEARCH   = 4'd4;
   localparam logic [3:0] S_END_RD   = 4'd5;
   localparam logic [3:0] S_UNLINK_A = 4'd6;
   localparam logic [3:0] S_UNLINK_B = 4'd7;
   localparam logic [3:0] S_UNLINK_C = 4'd8;
   localparam logic [3:0] S_DONE     = 4'd9;

   // Control state.
   logic [3:0]        state_ff, state_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  back_ff, back_in;
   logic [IDX_W-1:0]  free_head_ff, free_head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers of the item in progress.
   logic [OP_W-1:0]       op_ff, op_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [IDX_W-1:0]      node_ff, node_in;
   logic [IDX_W-1:0]      left_ff, left_in;
   logic [IDX_W-1:0]      right_ff, right_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [FIELD_W-1:0]    data_ff, data_in;
   logic                  found_ff, found_in;

   // Result register.
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic [LEN_W-1:0]    rsp_length_ff, rsp_length_in;

   // Node memory port signals.
   dlle_pkg::field_we_type mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   logic [DATA_WIDTH-1:0]  mem_wr_val;
   logic [IDX_W-1:0]       mem_wr_nxt;
   logic [IDX_W-1:0]       mem_wr_prv;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [DATA_WIDTH-1:0]  mem_rd_val;
   logic [IDX_W-1:0]       mem_rd_nxt;
   logic [IDX_W-1:0]       mem_rd_prv;

   logic                  slot_free;
   logic                  fresh_node;
   logic [DATA_WIDTH-1:0] req_key_w;
   logic [DATA_WIDTH-1:0] req_value_w;

   dlle_node_ram #(
      .NODE_COUNT (NODE_COUNT),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_val  (mem_wr_val),
      .wr_nxt  (mem_wr_nxt),
      .wr_prv  (mem_wr_prv),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_val  (mem_rd_val),
      .rd_nxt  (mem_rd_nxt),
      .rd_prv  (mem_rd_prv)
   );

   // Keys and values are sign-extended from 32 bits, then kept at the node width.
   assign req_key_w   = DATA_WIDTH'(req_key);
   assign req_value_w = DATA_WIDTH'(req_value);

   // The engine takes a new item whenever the sequencer is idle; a pending result does not block.
   assign req_stall = (state_ff != S_IDLE);

   // The result register can take a new result when it is empty or being drained this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // A node at the fill mark has never been handed out, so its next link is implicit.
   assign fresh_node = (fill_ff == FILL_W'(node_ff));

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      node_in       = node_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      found_in      = found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_length_in = rsp_length_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      mem_wr_en   = '0;
      mem_wr_addr = '0;
      mem_wr_val  = value_ff;
      mem_wr_nxt  = '0;
      mem_wr_prv  = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               key_in    = req_key_w;
               value_in  = req_value_w;
               status_in = dlle_pkg::STATUS_OK;
               data_in   = '0;
               found_in  = 1'b0;
               state_in  = S_DONE;
               case (req_operation)
                  dlle_pkg::OP_PUSH_FRONT, dlle_pkg::OP_PUSH_BACK: begin
                     // New node goes between the sentinel and the current end.
                     if (req_operation == dlle_pkg::OP_PUSH_FRONT) begin
                        left_in  = '0;
                        right_in = front_ff;
                     end else begin
                        left_in  = back_ff;
                        right_in = '0;
                     end
                     if (free_head_ff == '0) begin
                        status_in = dlle_pkg::STATUS_FULL;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = free_head_ff;
                        node_in     = free_head_ff;
                        state_in    = S_ALLOC;
                     end
                  end
                  dlle_pkg::OP_INS_AFTER, dlle_pkg::OP_INS_BEFORE,
                  dlle_pkg::OP_REMOVE_KEY, dlle_pkg::OP_FIND: begin
                     if (front_ff == '0) begin
                        status_in = dlle_pkg::STATUS_NOT_FOUND;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = front_ff;
                        node_in     = front_ff;
                        state_in    = S_SEARCH;
                     end
                  end
                  dlle_pkg::OP_PEEK_FRONT, dlle_pkg::OP_PEEK_BACK,
                  dlle_pkg::OP_POP_FRONT, dlle_pkg::OP_POP_BACK,
                  dlle_pkg::OP_DROP_FRONT, dlle_pkg::OP_DROP_BACK: begin
                     if (front_ff == '0) begin
                        status_in = dlle_pkg::STATUS_EMPTY;
                     end else begin
                        // Odd codes work on the back end, even codes on the front.
                        node_in     = req_operation[0] ? back_ff : front_ff;
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = req_operation[0] ? back_ff : front_ff;
                        state_in    = S_END_RD;
                     end
                  end
                  dlle_pkg::OP_CLEAR: begin
                     // Splice the whole list in front of the free chain in one write.
                     if (front_ff != '0) begin
                        mem_wr_en.nxt = 1'b1;
                        mem_wr_addr   = back_ff;
                        mem_wr_nxt    = free_head_ff;
                        free_head_in  = front_ff;
                     end
                     front_in = '0;
                     back_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_ALLOC: begin
            // The free head node is read; take it off the chain and fill it in.
            if (fresh_node) begin
               free_head_in = (node_ff == IDX_W'(NODE_COUNT - 1)) ? '0 : node_ff + IDX_W'(1);
               fill_in      = fill_ff + FILL_W'(1);
            end else begin
               free_head_in = mem_rd_nxt;
            end
            mem_wr_en   = '1;
            mem_wr_addr = node_ff;
            mem_wr_val  = value_ff;
            mem_wr_nxt  = right_ff;
            mem_wr_prv  = left_ff;
            count_in    = count_ff + IDX_W'(1);
            state_in    = S_LINK;
         end

         S_LINK: begin
            if (left_ff == '0) begin
               front_in = node_ff;
               if (right_ff == '0) begin
                  back_in = node_ff;
               end else begin
                  mem_wr_en.prv = 1'b1;
                  mem_wr_addr   = right_ff;
                  mem_wr_prv    = node_ff;
               end
               state_in = S_DONE;
            end else begin
               mem_wr_en.nxt = 1'b1;
               mem_wr_addr   = left_ff;
               mem_wr_nxt    = node_ff;
               if (right_ff == '0) begin
                  back_in  = node_ff;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LINK_B;
               end
            end
         end

         S_LINK_B: begin
            mem_wr_en.prv = 1'b1;
            mem_wr_addr   = right_ff;
            mem_wr_prv    = node_ff;
            state_in      = S_DONE;
         end

         S_SEARCH: begin
            if (mem_rd_val == key_ff) begin
               case (op_ff)
                  dlle_pkg::OP_FIND: begin
                     found_in = 1'b1;
                     state_in = S_DONE;
                  end
                  dlle_pkg::OP_INS_AFTER, dlle_pkg::OP_INS_BEFORE: begin
                     if (op_ff == dlle_pkg::OP_INS_AFTER) begin
                        left_in  = node_ff;
                        right_in = mem_rd_nxt;
                     end else begin
                        left_in  = mem_rd_prv;
                        right_in = node_ff;
                     end
                     // A missing key was ruled out first; now the pool decides.
                     if (free_head_ff == '0) begin
                        status_in = dlle_pkg::STATUS_FULL;
                        state_in  = S_DONE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = free_head_ff;
                        node_in     = free_head_ff;
                        state_in    = S_ALLOC;
                     end
                  end
                  default: begin
                     left_in  = mem_rd_prv;
                     right_in = mem_rd_nxt;
                     state_in = S_UNLINK_A;
                  end
               endcase
            end else if (mem_rd_nxt == '0) begin
               status_in = dlle_pkg::STATUS_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mem_rd_nxt;
               node_in     = mem_rd_nxt;
            end
         end

         S_END_RD: begin
            if (op_ff == dlle_pkg::OP_DROP_FRONT || op_ff == dlle_pkg::OP_DROP_BACK) begin
               data_in = '0;
            end else begin
               data_in = FIELD_W'(mem_rd_val);
            end
            if (op_ff == dlle_pkg::OP_PEEK_FRONT || op_ff == dlle_pkg::OP_PEEK_BACK) begin
               state_in = S_DONE;
            end else begin
               left_in  = mem_rd_prv;
               right_in = mem_rd_nxt;
               state_in = S_UNLINK_A;
            end
         end

         S_UNLINK_A: begin
            // Return the node to the free chain and fix any sentinel link in registers.
            mem_wr_en.nxt = 1'b1;
            mem_wr_addr   = node_ff;
            mem_wr_nxt    = free_head_ff;
            free_head_in  = node_ff;
            if (count_ff != '0) begin
               count_in = count_ff - IDX_W'(1);
            end
            if (left_ff == '0) begin
               front_in = right_ff;
            end
            if (right_ff == '0) begin
               back_in = left_ff;
            end
            if (left_ff != '0) begin
               state_in = S_UNLINK_B;
            end else if (right_ff != '0) begin
               state_in = S_UNLINK_C;
            end else begin
               state_in = S_DONE;
            end
         end

         S_UNLINK_B: begin
            mem_wr_en.nxt = 1'b1;
            mem_wr_addr   = left_ff;
            mem_wr_nxt    = right_ff;
            state_in      = (right_ff != '0) ? S_UNLINK_C : S_DONE;
         end

         S_UNLINK_C: begin
            mem_wr_en.prv = 1'b1;
            mem_wr_addr   = right_ff;
            mem_wr_prv    = left_ff;
            state_in      = S_DONE;
         end

         S_DONE: begin
            // All list updates are in; load the result once the output register has room.
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = data_ff;
               rsp_found_in  = found_ff;
               rsp_empty_in  = (front_ff == '0);
               rsp_length_in = LEN_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         free_head_ff <= IDX_W'(1);
         fill_ff      <= FILL_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      node_ff       <= node_in;
      left_ff       <= left_in;
      right_ff      <= right_in;
      status_ff     <= status_in;
      data_ff       <= data_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = $signed(rsp_data_ff);
   assign rsp_found    = rsp_found_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign rsp_length   = rsp_length_ff;

   // The sequencer never reads and writes the node memory in the same cycle, so no entry
   // can be read while it is being changed.
   a_no_mem_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && (mem_wr_en.val || mem_wr_en.nxt || mem_wr_en.prv)))
      else $error("node memory read and written in the same cycle");

   // Between items the sentinel links and the count agree on whether the list is empty.
   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((front_ff == '0) == (count_ff == '0) &&
                                (back_ff == '0) == (count_ff == '0)))
      else $error("sentinel links disagree with the stored count");

   // Between items every node is either on the list or on the free chain.
   a_pool_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((free_head_ff == '0) == (count_ff == IDX_W'(NODE_COUNT - 1))))
      else $error("free chain state disagrees with the stored count");

endmodule

// ===== hdl/dlle_node_ram.sv =====
// Node memory of the doubly linked list engine: value, next link and prev link per node.
// One write port with per-field enables, one registered read port.
// Depends on dlle_pkg.
module dlle_node_ram #(
   parameter int NODE_COUNT = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  dlle_pkg::field_we_type        wr_en,
   input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_val,
   input  logic [$clog2(NODE_COUNT)-1:0] wr_nxt,
   input  logic [$clog2(NODE_COUNT)-1:0] wr_prv,
   input  logic                          rd_en,
   input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_val,
   output logic [$clog2(NODE_COUNT)-1:0] rd_nxt,
   output logic [$clog2(NODE_COUNT)-1:0] rd_prv
);

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int WORD_W = DATA_WIDTH + 2 * IDX_W;

   // Word layout: value in the top bits, then next link, then prev link.
   logic [WORD_W-1:0] mem [NODE_COUNT];
   logic [WORD_W-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en.val) begin
         mem[wr_addr][WORD_W-1 -: DATA_WIDTH] <= wr_val;
      end
      if (wr_en.nxt) begin
         mem[wr_addr][2*IDX_W-1 -: IDX_W] <= wr_nxt;
      end
      if (wr_en.prv) begin
         mem[wr_addr][IDX_W-1:0] <= wr_prv;
      end
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_val = rd_word_ff[WORD_W-1 -: DATA_WIDTH];
   assign rd_nxt = rd_word_ff[2*IDX_W-1 -: IDX_W];
   assign rd_prv = rd_word_ff[IDX_W-1:0];

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for doubly_linked_list_engine, a bounded circular list of signed values.
// It predicts every result with a queue model of the list and checks the results field by field.
// Depends on dlle_pkg and doubly_linked_list_engine.
module testbench;

   // The pool holds every node but the sentinel.
   localparam int LIST_CAPACITY = 255;
   // Codes 13 to 15 carry no operation; the engine reports success and changes nothing.
   localparam logic [dlle_pkg::OP_W-1:0] OP_FIRST_SPARE = 4'd13;
   localparam logic [dlle_pkg::OP_W-1:0] OP_LAST_SPARE  = 4'd15;
   // The longest legal quiet stretch is the receiver hold-off plus a walk of a full list.
   localparam int QUIET_LIMIT = 4000;
   // Cycles to wait after the last result, so that a stray extra result is still caught.
   localparam int DRAIN_CYCLES = 400;
   localparam int HOLD_CYCLES = 150;
   localparam int HOLD_AFTER_ITEMS = 40;

   typedef struct {
      logic [dlle_pkg::OP_W-1:0]           operation;
      logic signed [dlle_pkg::FIELD_W-1:0] key;
      logic signed [dlle_pkg::FIELD_W-1:0] value;
   } list_op_type;

   typedef struct {
      logic [dlle_pkg::STATUS_W-1:0]       status;
      logic signed [dlle_pkg::FIELD_W-1:0] data_out;
      logic                                found;
      logic                                is_empty;
      logic [dlle_pkg::LEN_W-1:0]          length;
   } list_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_operation = '0;
   logic signed [31:0] req_key = '0;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_data_out;
   logic rsp_found;
   logic rsp_is_empty;
   logic [7:0] rsp_length;

   // Items waiting to be offered, the predicted list contents, and the results still to come.
   list_op_type                         pending_ops[$];
   logic signed [dlle_pkg::FIELD_W-1:0] list_contents[$];
   list_result_type                     awaited_results[$];
   list_op_type                         next_op;

   int  mismatch_count = 0;
   int  items_taken = 0;
   int  quiet_cycles = 0;
   logic req_taken = 1'b0;

   // Idling of each side, in percent of cycles; the stimulus process sets these per phase.
   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   int  hold_left = 0;
   logic hold_done = 1'b0;

   doubly_linked_list_engine dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_key      (req_key),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_found    (rsp_found),
      .rsp_is_empty (rsp_is_empty),
      .rsp_length   (rsp_length)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Applies one operation to the list model and returns the result the engine must give.
   // A key search always scans from the front and stops at the first equal value, so the
   // position of a hit is all that insert, remove and find need.
   task automatic apply_list_op(input list_op_type item, output list_result_type res);
      int  hit;
      logic from_back;
      hit = -1;
      foreach (list_contents[i])
         if (hit < 0 && list_contents[i] == item.key) hit = i;
      from_back = (item.operation == dlle_pkg::OP_PEEK_BACK ||
                   item.operation == dlle_pkg::OP_POP_BACK ||
                   item.operation == dlle_pkg::OP_DROP_BACK);
      res = '{default: '0};
      res.status = dlle_pkg::STATUS_OK;
      case (item.operation)
         dlle_pkg::OP_PUSH_FRONT, dlle_pkg::OP_PUSH_BACK: begin
            if (list_contents.size() >= LIST_CAPACITY) begin
               res.status = dlle_pkg::STATUS_FULL;
            end else if (item.operation == dlle_pkg::OP_PUSH_FRONT) begin
               list_contents.push_front(item.value);
            end else begin
               list_contents.push_back(item.value);
            end
         end
         dlle_pkg::OP_INS_AFTER, dlle_pkg::OP_INS_BEFORE: begin
            // A missing key is reported even when the pool is also exhausted.
            if (hit < 0) begin
               res.status = dlle_pkg::STATUS_NOT_FOUND;
            end else if (list_contents.size() >= LIST_CAPACITY) begin
               res.status = dlle_pkg::STATUS_FULL;
            end else begin
               list_contents.insert((item.operation == dlle_pkg::OP_INS_AFTER) ? hit + 1 : hit,
                                    item.value);
            end
         end
         dlle_pkg::OP_PEEK_FRONT, dlle_pkg::OP_PEEK_BACK, dlle_pkg::OP_POP_FRONT,
         dlle_pkg::OP_POP_BACK, dlle_pkg::OP_DROP_FRONT, dlle_pkg::OP_DROP_BACK: begin
            if (list_contents.size() == 0) begin
               res.status = dlle_pkg::STATUS_EMPTY;
            end else begin
               // Peek and pop return the end value; drop discards it silently.
               if (item.operation <= dlle_pkg::OP_POP_BACK)
                  res.data_out = from_back ? list_contents[$] : list_contents[0];
               if (item.operation >= dlle_pkg::OP_POP_FRONT) begin
                  if (from_back) void'(list_contents.pop_back());
                  else void'(list_contents.pop_front());
               end
            end
         end
         dlle_pkg::OP_REMOVE_KEY: begin
            if (hit < 0) res.status = dlle_pkg::STATUS_NOT_FOUND;
            else list_contents.delete(hit);
         end
         dlle_pkg::OP_FIND: begin
            if (hit < 0) res.status = dlle_pkg::STATUS_NOT_FOUND;
            else res.found = 1'b1;
         end
         dlle_pkg::OP_CLEAR: list_contents.delete();
         default: ;
      endcase
      res.is_empty = (list_contents.size() == 0);
      res.length = 8'(list_contents.size());
   endtask

   task automatic check_list_result();
      list_result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result with none awaited, status", 32'(rsp_status), 0);
      end else begin
         want = awaited_results.pop_front();
         if (rsp_status !== want.status)
            report_mismatch("status", 32'(rsp_status), 32'(want.status));
         if (rsp_data_out !== want.data_out)
            report_mismatch("data_out", rsp_data_out, want.data_out);
         if (rsp_found !== want.found)
            report_mismatch("found", 32'(rsp_found), 32'(want.found));
         if (rsp_is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(rsp_is_empty), 32'(want.is_empty));
         if (rsp_length !== want.length)
            report_mismatch("length", 32'(rsp_length), 32'(want.length));
      end
   endtask

   function automatic list_op_type make_op(input logic [dlle_pkg::OP_W-1:0] operation,
                                           input logic signed [dlle_pkg::FIELD_W-1:0] key,
                                           input logic signed [dlle_pkg::FIELD_W-1:0] value);
      list_op_type item;
      item.operation = operation;
      item.key = key;
      item.value = value;
      return item;
   endfunction

   // Most values come from a small set so that keys often hit; the rest use all 32 bits.
   function automatic logic signed [dlle_pkg::FIELD_W-1:0] random_word();
      if ($urandom_range(0, 99) < 70) return 32'($urandom_range(0, 15));
      return 32'($urandom);
   endfunction

   // The mix leans toward growth so the list spends most of its time holding a few values.
   function automatic logic [dlle_pkg::OP_W-1:0] random_operation();
      int r;
      r = $urandom_range(0, 99);
      if (r < 16) return dlle_pkg::OP_PUSH_FRONT;
      if (r < 32) return dlle_pkg::OP_PUSH_BACK;
      if (r < 40) return dlle_pkg::OP_INS_AFTER;
      if (r < 48) return dlle_pkg::OP_INS_BEFORE;
      if (r < 53) return dlle_pkg::OP_PEEK_FRONT;
      if (r < 58) return dlle_pkg::OP_PEEK_BACK;
      if (r < 64) return dlle_pkg::OP_POP_FRONT;
      if (r < 70) return dlle_pkg::OP_POP_BACK;
      if (r < 74) return dlle_pkg::OP_DROP_FRONT;
      if (r < 78) return dlle_pkg::OP_DROP_BACK;
      if (r < 86) return dlle_pkg::OP_REMOVE_KEY;
      if (r < 95) return dlle_pkg::OP_FIND;
      if (r < 97) return dlle_pkg::OP_CLEAR;
      return 4'($urandom_range(OP_FIRST_SPARE, OP_LAST_SPARE));
   endfunction

   task automatic queue_random_ops(input int count);
      repeat (count) pending_ops.push_back(make_op(random_operation(), random_word(),
                                                   random_word()));
   endtask

   // Fills the pool to the last node, probes every operation on a full list, then empties it.
   // Values stay in the small set during the fill, so the large key below is surely absent.
   task automatic queue_fill_burst();
      logic [dlle_pkg::OP_W-1:0] grow_op;
      repeat (200) begin
         case ($urandom_range(0, 3))
            0: grow_op = dlle_pkg::OP_PUSH_FRONT;
            1: grow_op = dlle_pkg::OP_PUSH_BACK;
            2: grow_op = dlle_pkg::OP_INS_AFTER;
            default: grow_op = dlle_pkg::OP_INS_BEFORE;
         endcase
         pending_ops.push_back(make_op(grow_op, 32'($urandom_range(0, 15)),
                                       32'($urandom_range(0, 15))));
      end
      repeat (70) pending_ops.push_back(make_op(dlle_pkg::OP_PUSH_BACK, '0,
                                                32'($urandom_range(0, 15))));
      pending_ops.push_back(make_op(dlle_pkg::OP_PUSH_FRONT, '0, 32'h1234_5678));
      pending_ops.push_back(make_op(dlle_pkg::OP_PUSH_BACK, '0, 32'h1234_5678));
      pending_ops.push_back(make_op(dlle_pkg::OP_INS_AFTER, 32'd3, 32'd99));
      pending_ops.push_back(make_op(dlle_pkg::OP_INS_BEFORE, 32'h7FFF_0000, 32'd99));
      pending_ops.push_back(make_op(dlle_pkg::OP_FIND, 32'h7FFF_0000, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_FIND, 32'd15, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_REMOVE_KEY, 32'd7, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_INS_BEFORE, 32'd9, 32'h8765_4321));
      pending_ops.push_back(make_op(dlle_pkg::OP_PUSH_BACK, '0, 32'd1));
      pending_ops.push_back(make_op(dlle_pkg::OP_PEEK_FRONT, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_PEEK_BACK, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_POP_FRONT, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_POP_BACK, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_DROP_FRONT, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_DROP_BACK, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_CLEAR, '0, '0));
   endtask

   // Directed opening: operations on an empty list, extreme values, hits and misses of a key,
   // every end operation, the spare codes, and a clear of a list that holds values.
   task automatic queue_directed_ops();
      pending_ops.push_back(make_op(dlle_pkg::OP_PEEK_FRONT, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_POP_BACK, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_DROP_FRONT, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_FIND, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_INS_AFTER, '0, 32'd1));
      pending_ops.push_back(make_op(dlle_pkg::OP_REMOVE_KEY, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_CLEAR, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 32'h8000_0000));
      pending_ops.push_back(make_op(dlle_pkg::OP_PUSH_BACK, 32'h8000_0000, 32'h7FFF_FFFF));
      pending_ops.push_back(make_op(dlle_pkg::OP_PUSH_FRONT, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_PUSH_BACK, '0, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(dlle_pkg::OP_INS_AFTER, 32'h8000_0000, 32'd5));
      pending_ops.push_back(make_op(dlle_pkg::OP_INS_BEFORE, 32'h7FFF_FFFF, 32'hFFFF_FFFB));
      pending_ops.push_back(make_op(dlle_pkg::OP_INS_BEFORE, 32'h5555_AAAA, 32'd6));
      pending_ops.push_back(make_op(dlle_pkg::OP_FIND, 32'h7FFF_FFFF, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_PEEK_FRONT, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_PEEK_BACK, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_POP_FRONT, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_POP_BACK, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_DROP_FRONT, '0, '0));
      pending_ops.push_back(make_op(OP_FIRST_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(OP_LAST_SPARE, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_REMOVE_KEY, 32'd5, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_DROP_BACK, '0, '0));
      pending_ops.push_back(make_op(dlle_pkg::OP_CLEAR, '0, '0));
   endtask

   task automatic wait_queue_drained();
      while (pending_ops.size() != 0) @(posedge clock);
   endtask

   // Sender: a new item goes out at the falling edge only once the previous one was taken,
   // so a stalled item keeps its payload and valid never looks at the stall.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ops.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_op = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_operation <= next_op.operation;
            req_key <= next_op.key;
            req_value <= next_op.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls per phase, plus one long hold-off early in the run while the
   // sender keeps offering items, so that the engine backs up into its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_taken >= HOLD_AFTER_ITEMS) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   // Monitor: at the rising edge, checks the result taken, predicts the item taken, and runs
   // the watchdog on cycles in which neither side moves anything.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_list_result();
         if (req_valid && !req_stall) begin
            list_result_type res;
            apply_list_op(make_op(req_operation, req_key, req_value), res);
            awaited_results.push_back(res);
            items_taken++;
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // Stimulus: four idling phases; the fill bursts run once with no idling and once with the
   // receiver stalling, and the random items fill in between.
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      queue_directed_ops();
      queue_fill_burst();
      queue_random_ops(200);
      wait_queue_drained();

      sender_idle_pct = 78;
      receiver_stall_pct = 0;
      queue_random_ops(420);
      wait_queue_drained();

      sender_idle_pct = 0;
      receiver_stall_pct = 78;
      queue_fill_burst();
      queue_random_ops(200);
      wait_queue_drained();

      sender_idle_pct = 17;
      receiver_stall_pct = 17;
      queue_random_ops(420);

      // Let everything be taken and answered, then watch a while longer for stray results.
      while (pending_ops.size() != 0 || req_valid) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
